>>> rtl/ps2kr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kr_pkg
// shared types and constants of the ps/2 keyboard receiver
// ----------------------------------------------------------------------------
package ps2kr_pkg;

  localparam int unsigned CODE_W    = 9;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [BYTE_W-1:0]  CODE_EXT  = 8'hE0;
  localparam logic [BYTE_W-1:0]  CODE_REL  = 8'hF0;
  localparam logic [COUNT_W-1:0] FIRST_DATA_EDGE = 4'd1;
  localparam logic [COUNT_W-1:0] LAST_DATA_EDGE  = 4'd8;
  localparam logic [COUNT_W-1:0] LAST_EDGE = 4'd10;

  localparam logic [CODE_W-1:0] LEFT_CTRL_RESET   = 9'd20;
  localparam logic [CODE_W-1:0] RIGHT_CTRL_RESET  = 9'd276;
  localparam logic [CODE_W-1:0] LEFT_SHIFT_RESET  = 9'd18;
  localparam logic [CODE_W-1:0] RIGHT_SHIFT_RESET = 9'd89;

  typedef enum logic [1:0] {
    PFX_NORMAL  = 2'd0,
    PFX_EXT     = 2'd1,
    PFX_EXT_REL = 2'd2,
    PFX_REL     = 2'd3
  } prefix_t;

  typedef enum logic [1:0] {
    MOD_NONE  = 2'd0,
    MOD_SHIFT = 2'd1,
    MOD_CTRL  = 2'd2
  } modifier_t;

  typedef enum logic [1:0] {
    REG_LEFT_CTRL   = 2'd0,
    REG_RIGHT_CTRL  = 2'd1,
    REG_LEFT_SHIFT  = 2'd2,
    REG_RIGHT_SHIFT = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [CODE_W-1:0] left_ctrl;
    logic [CODE_W-1:0] right_ctrl;
    logic [CODE_W-1:0] left_shift;
    logic [CODE_W-1:0] right_shift;
  } cfg_t;

  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] data;
  } frame_t;

  typedef struct packed {
    logic              key_valid;
    logic [CODE_W-1:0] key_code;
    logic [1:0]        modifier;
  } result_t;

endpackage

>>> rtl/ps2_keyboard_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2_keyboard_receiver
// ps/2 scan code set 2 receiver with prefix decoding and modifier tracking
//
//   channel   dir  handshake          contents
//   s_*       in   s_tvalid/s_tready  one keyboard clock edge, sampled data line
//   m_*       out  m_tvalid/m_tready  key code and modifier, one per frame
//   apb       in   psel/penable       four 9-bit modifier code registers
//
// one request per cycle is taken; the frame counter updates on each accept
// and the prefix machine on the accept that closes a frame, which also loads
// the output register. the input keeps taking requests while that register
// is empty or being drained, so only a held result with m_tready low stalls.
// synchronous reset clears counters, prefix state, modifier and the output
// valid; the code registers return to their defaults.
// ----------------------------------------------------------------------------
module ps2_keyboard_receiver import ps2kr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [0] data_bit, [7:1] zero
  // result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [15:0]           m_tdata,   // [8:0] key_code, [10:9] modifier, [15:11] zero
  output logic                  m_tuser,   // [0] key_valid
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t       cfg;
  frame_t     frame;
  result_t    result;
  logic       step;
  logic       cfg_write;
  reg_index_t cfg_index;
  logic [CODE_W-1:0] rd_code;

  // ---------------------------------------------------------------- config
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_index = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.left_ctrl   <= LEFT_CTRL_RESET;
      cfg.right_ctrl  <= RIGHT_CTRL_RESET;
      cfg.left_shift  <= LEFT_SHIFT_RESET;
      cfg.right_shift <= RIGHT_SHIFT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_LEFT_CTRL:   cfg.left_ctrl   <= pwdata[CODE_W-1:0];
        REG_RIGHT_CTRL:  cfg.right_ctrl  <= pwdata[CODE_W-1:0];
        REG_LEFT_SHIFT:  cfg.left_shift  <= pwdata[CODE_W-1:0];
        REG_RIGHT_SHIFT: cfg.right_shift <= pwdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux, zero extended to the bus width
  always_comb begin
    unique case (cfg_index)
      REG_LEFT_CTRL:   rd_code = cfg.left_ctrl;
      REG_RIGHT_CTRL:  rd_code = cfg.right_ctrl;
      REG_LEFT_SHIFT:  rd_code = cfg.left_shift;
      REG_RIGHT_SHIFT: rd_code = cfg.right_shift;
      default:         rd_code = '0;
    endcase
  end
  assign prdata = {{(CFG_DATA_W-CODE_W){1'b0}}, rd_code};

  // ---------------------------------------------------------------- input
  // output register acts as the stage boundary: free or draining means go
  assign s_tready = !m_tvalid || m_tready;
  assign step     = s_tvalid && s_tready;

  ps2kr_frame u_frame (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .data_bit (s_tdata[0]),
    .frame    (frame)
  );

  ps2kr_decode u_decode (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .frame  (frame),
    .cfg    (cfg),
    .result (result)
  );

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step && frame.done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // payload loads only when a frame closes
  always_ff @(posedge clk) begin
    if (step && frame.done) begin
      m_tdata <= {5'b0, result.modifier, result.key_code};
      m_tuser <= result.key_valid;
    end
  end

endmodule

>>> rtl/ps2kr_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kr_frame
// edge counter and serial-in shift register for one frame
// ----------------------------------------------------------------------------
module ps2kr_frame import ps2kr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   step,
  input  logic   data_bit,
  output frame_t frame
);

  logic [COUNT_W-1:0] edge_count;
  logic [COUNT_W-1:0] edge_count_next;
  logic [BYTE_W-1:0]  shift_byte;
  logic [BYTE_W-1:0]  shift_byte_next;
  logic               done;

  // counts past the last edge also close the frame
  assign done       = (edge_count >= LAST_EDGE);
  assign frame.done = done;
  assign frame.data = shift_byte;

  always_comb begin
    shift_byte_next = shift_byte;
    if (edge_count >= FIRST_DATA_EDGE && edge_count <= LAST_DATA_EDGE) begin
      shift_byte_next = {data_bit, shift_byte[BYTE_W-1:1]};
    end
    if (done) begin
      edge_count_next = '0;
      shift_byte_next = '0;
    end else begin
      edge_count_next = edge_count + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
      shift_byte <= '0;
    end else if (step) begin
      edge_count <= edge_count_next;
      shift_byte <= shift_byte_next;
    end
  end

endmodule

>>> rtl/ps2kr_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ps2kr_decode
// prefix state machine and modifier tracking for completed bytes
// ----------------------------------------------------------------------------
module ps2kr_decode import ps2kr_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    step,
  input  frame_t  frame,
  input  cfg_t    cfg,
  output result_t result
);

  prefix_t           state;
  prefix_t           state_next;
  modifier_t         modifier;
  modifier_t         modifier_next;
  logic              apply;
  logic              pressed;
  logic [CODE_W-1:0] code;
  logic              is_ctrl;
  logic              is_shift;
  logic              valid;

  assign is_ctrl  = (code == cfg.left_ctrl) || (code == cfg.right_ctrl);
  assign is_shift = (code == cfg.left_shift) || (code == cfg.right_shift);

  always_comb begin
    state_next    = state;
    modifier_next = modifier;
    apply         = 1'b0;
    pressed       = 1'b0;
    code          = {1'b0, frame.data};
    unique case (state)
      PFX_NORMAL: begin
        if (frame.data == CODE_EXT) begin
          state_next = PFX_EXT;
        end else if (frame.data == CODE_REL) begin
          state_next = PFX_REL;
        end else begin
          apply      = 1'b1;
          pressed    = 1'b1;
          state_next = PFX_NORMAL;
        end
      end
      PFX_EXT: begin
        code = {1'b1, frame.data};
        if (frame.data == CODE_REL) begin
          state_next = PFX_EXT_REL;
        end else begin
          apply      = 1'b1;
          pressed    = 1'b1;
          state_next = PFX_NORMAL;
        end
      end
      PFX_EXT_REL: begin
        code       = {1'b1, frame.data};
        apply      = 1'b1;
        state_next = PFX_NORMAL;
      end
      PFX_REL: begin
        apply      = 1'b1;
        state_next = PFX_NORMAL;
      end
      default: begin
        state_next = PFX_NORMAL;
      end
    endcase

    // ctrl wins when a code matches both kinds
    if (apply && is_ctrl) begin
      modifier_next = pressed ? MOD_CTRL : MOD_NONE;
    end else if (apply && is_shift) begin
      modifier_next = pressed ? MOD_SHIFT : MOD_NONE;
    end

    valid            = apply && pressed && !is_ctrl && !is_shift;
    result.key_valid = valid;
    result.key_code  = valid ? code : '0;
    result.modifier  = modifier_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= PFX_NORMAL;
      modifier <= MOD_NONE;
    end else if (step && frame.done) begin
      state    <= state_next;
      modifier <= modifier_next;
    end
  end

endmodule

>>> bench/tb_ps2_keyboard_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ps2_keyboard_receiver
// self-checking bench for the ps/2 scan code receiver
//
// keyboard edges go in one request at a time on the s_* stream, one frame
// per byte. a mirror of the frame counter, the prefix machine and the
// modifier tracking predicts one result per frame, and every result taken
// from the m_* stream is checked field by field against the oldest
// prediction. a short scripted sequence runs first, then random key events,
// over several code register settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_ps2_keyboard_receiver;
  import ps2kr_pkg::*;

  localparam int PHASES       = 8;
  localparam int PHASE_EDGES  = 160;  // random edges per phase, ~1650 total with the script
  localparam int SETTLE_TICKS = 4;    // result is registered on the accept of the last edge

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = '0;    // [0] data_bit, [7:1] zero
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [15:0]           m_tdata;         // [8:0] key_code, [10:9] modifier, [15:11] zero
  logic                  m_tuser;         // [0] key_valid
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  ps2_keyboard_receiver dut (
    .clk, .rst,
    .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk = ~clk;

  // mirror of the receiver state
  cfg_t        codes = '{LEFT_CTRL_RESET, RIGHT_CTRL_RESET, LEFT_SHIFT_RESET,
                         RIGHT_SHIFT_RESET};
  logic [3:0]  rx_edges = '0;
  logic [7:0]  rx_byte = '0;
  prefix_t     rx_prefix = PFX_NORMAL;
  modifier_t   held_mod = MOD_NONE;

  result_t     key_queue[$];    // predicted results, oldest first
  int          fails = 0;
  int          edges_sent = 0;
  int          src_idle = 0;    // percent of cycles the sender holds off
  int          sink_stall = 0;  // percent of cycles the receiver stalls

  // scripted rows may carry a hand-written result for their frame
  logic        hand_typed = 1'b0;
  result_t     hand_want = '0;

  typedef struct {
    logic [7:0] code_byte;
    logic       bad_frame;  // start, parity and stop all wrong
    logic       typed;
    result_t    want;
  } script_row_t;

  // runs at reset codes: left ctrl 14, right ctrl e0 14, shifts 12 and 59
  script_row_t script [27] = '{
    '{8'h1C, 1'b0, 1'b1, '{1'b1, 9'h01C, MOD_NONE}},   // plain press
    '{8'h00, 1'b0, 1'b1, '{1'b1, 9'h000, MOD_NONE}},   // lowest byte
    '{8'hFF, 1'b1, 1'b1, '{1'b1, 9'h0FF, MOD_NONE}},   // highest byte, bad framing
    '{8'h12, 1'b0, 1'b1, '{1'b0, 9'h000, MOD_SHIFT}},  // left shift down
    '{8'h1C, 1'b1, 1'b1, '{1'b1, 9'h01C, MOD_SHIFT}},
    '{8'h14, 1'b0, 1'b1, '{1'b0, 9'h000, MOD_CTRL}},   // left ctrl down
    '{8'hF0, 1'b0, 1'b1, '{1'b0, 9'h000, MOD_CTRL}},   // prefix alone
    '{8'h12, 1'b0, 1'b1, '{1'b0, 9'h000, MOD_NONE}},   // shift up clears ctrl too
    '{8'hE0, 1'b0, 1'b0, '0},
    '{8'h14, 1'b0, 1'b1, '{1'b0, 9'h000, MOD_CTRL}},   // right ctrl down
    '{8'hE0, 1'b0, 1'b0, '0},
    '{8'hF0, 1'b0, 1'b0, '0},
    '{8'h14, 1'b1, 1'b1, '{1'b0, 9'h000, MOD_NONE}},   // right ctrl up
    '{8'hE0, 1'b0, 1'b0, '0},
    '{8'hE0, 1'b0, 1'b1, '{1'b1, 9'h1E0, MOD_NONE}},   // second e0 is a code
    '{8'hF0, 1'b0, 1'b0, '0},
    '{8'hF0, 1'b0, 1'b1, '{1'b0, 9'h000, MOD_NONE}},   // f0 released after f0
    '{8'hE0, 1'b0, 1'b0, '0},
    '{8'hF0, 1'b0, 1'b0, '0},
    '{8'hE0, 1'b0, 1'b1, '{1'b0, 9'h000, MOD_NONE}},   // e0 released after e0 f0
    '{8'hF0, 1'b0, 1'b0, '0},
    '{8'h1C, 1'b0, 1'b1, '{1'b0, 9'h000, MOD_NONE}},   // key up gives nothing
    '{8'h59, 1'b0, 1'b1, '{1'b0, 9'h000, MOD_SHIFT}},  // right shift down
    '{8'hE0, 1'b0, 1'b0, '0},
    '{8'h7A, 1'b0, 1'b1, '{1'b1, 9'h17A, MOD_SHIFT}},  // extended press
    '{8'hF0, 1'b0, 1'b0, '0},
    '{8'hE0, 1'b1, 1'b1, '{1'b0, 9'h000, MOD_SHIFT}}   // e0 as released code
  };

  // ctrl wins over shift when a code matches both; any modifier release
  // drops back to none
  function automatic logic apply_key(input logic [8:0] code, input logic pressed);
    if (code == codes.left_ctrl || code == codes.right_ctrl) begin
      if (pressed) held_mod = MOD_CTRL;
      else held_mod = MOD_NONE;
      return 1'b0;
    end
    if (code == codes.left_shift || code == codes.right_shift) begin
      if (pressed) held_mod = MOD_SHIFT;
      else held_mod = MOD_NONE;
      return 1'b0;
    end
    return pressed;
  endfunction

  // one keyboard edge; got is set on the edge that closes a frame
  function automatic void decode_edge(input logic b, output logic got,
                                      output result_t res);
    logic [7:0] byte_in;
    logic [8:0] code;
    logic       valid;
    code  = '0;
    valid = 1'b0;
    got   = 1'b0;
    res   = '0;
    if (rx_edges >= FIRST_DATA_EDGE && rx_edges <= LAST_DATA_EDGE)
      rx_byte = {b, rx_byte[7:1]};
    if (rx_edges < LAST_EDGE) begin
      rx_edges = rx_edges + 4'd1;
      return;
    end
    byte_in  = rx_byte;
    rx_edges = '0;
    rx_byte  = '0;
    case (rx_prefix)
      PFX_NORMAL: begin
        if (byte_in == CODE_EXT) rx_prefix = PFX_EXT;
        else if (byte_in == CODE_REL) rx_prefix = PFX_REL;
        else begin
          code  = {1'b0, byte_in};
          valid = apply_key(code, 1'b1);
        end
      end
      PFX_EXT: begin
        if (byte_in == CODE_REL) rx_prefix = PFX_EXT_REL;
        else begin
          code      = {1'b1, byte_in};
          valid     = apply_key(code, 1'b1);
          rx_prefix = PFX_NORMAL;
        end
      end
      PFX_EXT_REL: begin
        void'(apply_key({1'b1, byte_in}, 1'b0));
        rx_prefix = PFX_NORMAL;
      end
      default: begin
        void'(apply_key({1'b0, byte_in}, 1'b0));
        rx_prefix = PFX_NORMAL;
      end
    endcase
    got           = 1'b1;
    res.key_valid = valid;
    res.key_code  = valid ? code : '0;
    res.modifier  = held_mod;
  endfunction

  // both handshakes are sampled at the rising edge: an accepted input
  // request is run through the mirror first, then any result taken this
  // edge is checked against the oldest prediction
  always @(posedge clk) begin : watch
    logic    got;
    result_t res;
    result_t seen;
    result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        decode_edge(s_tdata[0], got, res);
        if (got) begin
          if (hand_typed) begin
            res        = hand_want;
            hand_typed = 1'b0;
          end
          key_queue.push_back(res);
        end
      end
      if (m_tvalid && m_tready) begin
        seen = '{m_tuser, m_tdata[8:0], m_tdata[10:9]};
        if (key_queue.size() == 0) begin
          $error("unexpected result: key_valid %0d key_code %03h modifier %0d",
                 seen.key_valid, seen.key_code, seen.modifier);
          fails++;
        end else begin
          want = key_queue.pop_front();
          if (seen.key_valid !== want.key_valid) begin
            $error("key_valid: expected %0d, got %0d", want.key_valid, seen.key_valid);
            fails++;
          end
          if (seen.key_code !== want.key_code) begin
            $error("key_code: expected %03h, got %03h", want.key_code, seen.key_code);
            fails++;
          end
          if (seen.modifier !== want.modifier) begin
            $error("modifier: expected %0d, got %0d", want.modifier, seen.modifier);
            fails++;
          end
        end
      end
    end
  end

  // receiver side back-pressure
  always @(negedge clk) m_tready <= ($urandom_range(99) >= sink_stall);

  // all driving tasks start and end just after a falling edge
  task automatic send_edge(input logic b);
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, b};
    do @(posedge clk); while (!s_tready);
    edges_sent++;
    @(negedge clk);
  endtask

  // framing is {stop, parity, start}, data goes out lsb first
  task automatic send_frame(input logic [7:0] v, input logic [2:0] framing);
    send_edge(framing[0]);
    for (int i = 0; i < 8; i++) send_edge(v[i]);
    send_edge(framing[1]);
    send_edge(framing[2]);
  endtask

  // one key event: optional e0, optional f0, then the code byte;
  // a few events are plain noise bytes
  task automatic send_key_event();
    int         pick;
    logic [8:0] code;
    pick = $urandom_range(99);
    if (pick < 15) begin
      send_frame(8'($urandom_range(255)), 3'($urandom_range(7)));
      return;
    end
    if (pick < 50) begin
      case ($urandom_range(3))
        0: code = codes.left_ctrl;
        1: code = codes.right_ctrl;
        2: code = codes.left_shift;
        default: code = codes.right_shift;
      endcase
    end else if (pick < 60) begin
      code = {1'($urandom_range(1)), ($urandom_range(1) != 0) ? CODE_EXT : CODE_REL};
    end else begin
      code = 9'($urandom_range(511));
    end
    if (code[8]) send_frame(CODE_EXT, 3'($urandom_range(7)));
    if ($urandom_range(99) < 40) send_frame(CODE_REL, 3'($urandom_range(7)));
    send_frame(code[7:0], 3'($urandom_range(7)));
  endtask

  // drain: stop sending, wait for every predicted result, then wait out SETTLE_TICKS
  task automatic settle();
    s_tvalid <= 1'b0;
    while (key_queue.size() != 0) @(negedge clk);
    repeat (SETTLE_TICKS) @(negedge clk);
  endtask

  task automatic cfg_write(input reg_index_t idx, input logic [CODE_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{(CFG_DATA_W-CODE_W){1'b0}}, v};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LEFT_CTRL:   codes.left_ctrl = v;
      REG_RIGHT_CTRL:  codes.right_ctrl = v;
      REG_LEFT_SHIFT:  codes.left_shift = v;
      default:         codes.right_shift = v;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic cfg_check(input reg_index_t idx, input logic [CODE_W-1:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {{(CFG_DATA_W-CODE_W){1'b0}}, v}) begin
      $error("%s: expected %03h, got %0h", idx.name(), v, prdata);
      fails++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : stimulus
    cfg_t next;
    int   phase_start;
    logic [7:0] b;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int p = 0; p < PHASES; p++) begin
      if (p != 0) begin
        settle();
        case (p)
          1: next = '{9'h000, 9'h000, 9'h000, 9'h000};
          2: next = '{9'h1FF, 9'h1FF, 9'h1FF, 9'h1FF};
          3: next = '{9'h01C, 9'h1E0, 9'h01C, 9'h1F0};  // ctrl and shift overlap
          4: next = '{9'h0E0, 9'h0F0, 9'h100, 9'h0FF};  // ctrl codes on the prefix bytes
          6: next = '{LEFT_CTRL_RESET, RIGHT_CTRL_RESET, LEFT_SHIFT_RESET,
                      RIGHT_SHIFT_RESET};
          default: next = '{9'($urandom_range(511)), 9'($urandom_range(511)),
                            9'($urandom_range(511)), 9'($urandom_range(511))};
        endcase
        cfg_write(REG_LEFT_CTRL, next.left_ctrl);
        cfg_write(REG_RIGHT_CTRL, next.right_ctrl);
        cfg_write(REG_LEFT_SHIFT, next.left_shift);
        cfg_write(REG_RIGHT_SHIFT, next.right_shift);
        cfg_check(REG_LEFT_CTRL, next.left_ctrl);
        cfg_check(REG_RIGHT_CTRL, next.right_ctrl);
        cfg_check(REG_LEFT_SHIFT, next.left_shift);
        cfg_check(REG_RIGHT_SHIFT, next.right_shift);
      end

      // idle pattern rotates: none, sender, receiver, both
      case (p % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 60; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 60; end
        default: begin src_idle = 30; sink_stall = 30; end
      endcase

      if (p == 0) begin
        foreach (script[i]) begin
          b          = script[i].code_byte;
          hand_typed = script[i].typed;
          hand_want  = script[i].want;
          if (script[i].bad_frame) send_frame(b, {1'b0, ^b, 1'b1});
          else send_frame(b, {1'b1, ~^b, 1'b0});
        end
      end

      phase_start = edges_sent;
      while (edges_sent - phase_start < PHASE_EDGES) send_key_event();
    end

    settle();
    if (fails == 0) begin
      $display("tb_ps2_keyboard_receiver: done, clean");
    end else begin
      $display("tb_ps2_keyboard_receiver: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_ps2_keyboard_receiver: done, errors");
    $finish;
  end

endmodule

>>> sim.f
rtl/ps2kr_pkg.sv
rtl/ps2kr_frame.sv
rtl/ps2kr_decode.sv
rtl/ps2_keyboard_receiver.sv
bench/tb_ps2_keyboard_receiver.sv
